// ----- rtl/mftt_pkg.sv -----
`default_nettype none

package mftt_pkg;

  // Field widths fixed by the frame format.
  localparam int unsigned IdW     = 11;
  localparam int unsigned WordW   = 16;
  localparam int unsigned TempW   = 8;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned CountW  = 3;
  localparam int unsigned TurnW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // Default size of the slot table.
  localparam int unsigned SlotCountDefault = 8;

  // Tracking constants.
  localparam logic [SlotW-1:0]  GroupOffset = 3'd4;
  localparam logic [CountW-1:0] GroupMax    = 3'd4;
  localparam logic signed [WordW:0] JumpLimit    = 17'sd4096;
  localparam logic signed [WordW:0] JumpLimitNeg = -17'sd4096;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFirstBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondBase = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPerGroup   = 2'd2;

  // Configuration reset values.
  localparam logic [IdW-1:0]    FirstBaseReset  = 11'd513;
  localparam logic [IdW-1:0]    SecondBaseReset = 11'd517;
  localparam logic [CountW-1:0] PerGroupReset   = 3'd4;

  // One entry of the slot table.
  typedef struct packed {
    logic             seen;
    logic [TurnW-1:0] turns;
    logic [WordW-1:0] prev_angle;
  } entry_t;

  // Result of the identifier decode.
  typedef struct packed {
    logic             hit;
    logic             second;
    logic [SlotW-1:0] slot;
  } match_t;

endpackage

`default_nettype wire

// ----- rtl/mftt_decode.sv -----
`default_nettype none

module mftt_decode import mftt_pkg::*; #(
  parameter int unsigned SlotCount = SlotCountDefault
) (
  input  wire logic [IdW-1:0]    frame_id_i,
  input  wire logic [IdW-1:0]    first_base_i,
  input  wire logic [IdW-1:0]    second_base_i,
  input  wire logic [CountW-1:0] per_group_i,
  output match_t                 match_o
);

  logic [CountW-1:0] count;
  logic [IdW:0]      first_end;
  logic [IdW:0]      second_end;
  logic              in_first;
  logic              in_second;
  logic [1:0]        first_off;
  logic [1:0]        second_off;
  logic [SlotW-1:0]  slot;

  // Groups never span more than four identifiers.
  assign count = (per_group_i > GroupMax) ? GroupMax : per_group_i;

  // Range checks, one bit wider so that the end cannot wrap.
  assign first_end  = {1'b0, first_base_i} + {{(IdW + 1 - CountW){1'b0}}, count};
  assign second_end = {1'b0, second_base_i} + {{(IdW + 1 - CountW){1'b0}}, count};
  assign in_first   = (frame_id_i >= first_base_i) && ({1'b0, frame_id_i} < first_end);
  assign in_second  = (frame_id_i >= second_base_i) && ({1'b0, frame_id_i} < second_end);

  // Offsets within a group are below four once the range check holds.
  assign first_off  = 2'(frame_id_i - first_base_i);
  assign second_off = 2'(frame_id_i - second_base_i);

  // The first group takes precedence where the ranges overlap.
  always_comb begin
    match_o = '0;
    slot    = '0;
    if (in_first) begin
      slot = {1'b0, first_off};
    end else if (in_second) begin
      slot = {1'b0, second_off} + GroupOffset;
    end
    if ((in_first || in_second) && ({29'd0, slot} < 32'(SlotCount))) begin
      match_o.hit    = 1'b1;
      match_o.second = !in_first;
      match_o.slot   = slot;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mftt_table.sv -----
`default_nettype none

module mftt_table import mftt_pkg::*; #(
  parameter int unsigned SlotCount = SlotCountDefault,
  localparam int unsigned IdxW     = (SlotCount > 1) ? $clog2(SlotCount) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_idx_i,
  output entry_t               rd_entry_o,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire entry_t          wr_entry_i
);

  entry_t               mem_q [SlotCount];
  logic [SlotCount-1:0] valid_q;
  entry_t               rd_data_q;
  logic                 rd_valid_q;

  // Synchronous slot memory; read data stays until the next read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  // Per-entry valid bits stand in for clearing the memory at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  // An entry never written reads as all zeros.
  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/motor_feedback_multiturn_tracker_unit.sv -----
`default_nettype none

// Multi-turn angle tracker for motor feedback frames.
//
// Input channel: one received feedback frame per transfer (identifier and the
// angle, speed, current and temperature words), moved when in_valid_i is high
// and in_stall_o is low. Output channel: one result per frame, moved when
// out_valid_o is high and out_stall_i is low. A frame outside both identifier
// ranges yields a result with every field zero and leaves the table alone.
// Configuration: a write channel (cfg_valid_i, cfg_ready_o, cfg_index_i,
// cfg_data_i) that is always ready; write it only while the block is idle.
//
// For each frame the slot table is read in the transfer cycle, and the round
// update is written back and the result registered in the next. The next
// frame is taken from the cycle after that, so a new frame is not accepted
// while the last one is being updated; the registered read of the slot memory
// sets this. out_valid_o rises once the result is registered in the StCalc
// state. While the receiver stalls, the result is held in the output register
// and no further frame is taken until it has moved.
// Reset restores the default identifier ranges and marks all table entries
// unwritten, so that every slot starts with angle, rounds and flag at zero.

module motor_feedback_multiturn_tracker_unit import mftt_pkg::*; #(
  parameter int unsigned SlotCount = SlotCountDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Frame input
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [IdW-1:0]           frame_id_i,
  input  wire logic [WordW-1:0]         angle_word_i,
  input  wire logic signed [WordW-1:0]  speed_word_i,
  input  wire logic signed [WordW-1:0]  current_word_i,
  input  wire logic [TempW-1:0]         temp_byte_i,
  // Result output
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          matched_o,
  output logic [SlotW-1:0]              slot_o,
  output logic [WordW-1:0]              shaft_angle_o,
  output logic signed [WordW-1:0]       shaft_speed_o,
  output logic signed [WordW-1:0]       phase_current_o,
  output logic [TempW-1:0]              temperature_o,
  output logic signed [TurnW-1:0]       round_count_o,
  output logic signed [TurnW-1:0]       total_angle_o,
  // Configuration writes
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [IdW-1:0]           cfg_data_i
);

  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  typedef enum logic {
    StIdle,
    StCalc
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [IdW-1:0]    first_base_q;
  logic [IdW-1:0]    second_base_q;
  logic [CountW-1:0] per_group_q;

  // Frame held across the table read.
  match_t           match_q;
  logic [WordW-1:0] angle_q;
  logic [WordW-1:0] speed_q;
  logic [WordW-1:0] current_q;
  logic [TempW-1:0] temp_q;

  // Output register.
  logic             out_valid_q;
  logic             matched_q;
  logic [SlotW-1:0] slot_q;
  logic [WordW-1:0] shaft_angle_q;
  logic [WordW-1:0] shaft_speed_q;
  logic [WordW-1:0] phase_current_q;
  logic [TempW-1:0] temperature_q;
  logic [TurnW-1:0] round_count_q;
  logic [TurnW-1:0] total_angle_q;

  match_t            match;
  logic              in_fire;
  logic              out_free;
  logic              calc_done;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic signed [WordW:0] diff;
  logic              first_frame;
  logic [TurnW-1:0]  turns_after;
  logic [TurnW-1:0]  total;

  assign cfg_ready_o = 1'b1;

  // Handshakes: a frame is taken only when no update is pending and the output is not stalled.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign calc_done  = (state_q == StCalc) && out_free;

  mftt_decode #(
    .SlotCount(SlotCount)
  ) u_decode (
    .frame_id_i   (frame_id_i),
    .first_base_i (first_base_q),
    .second_base_i(second_base_q),
    .per_group_i  (per_group_q),
    .match_o      (match)
  );

  mftt_table #(
    .SlotCount(SlotCount)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire && match.hit),
    .rd_idx_i  (match.slot[IdxW-1:0]),
    .rd_entry_o(rd_entry),
    .wr_en_i   (calc_done && match_q.hit),
    .wr_idx_i  (match_q.slot[IdxW-1:0]),
    .wr_entry_i(wr_entry)
  );

  // Round step: a jump of more than half a turn crosses the zero mark.
  assign diff        = $signed({1'b0, angle_q}) - $signed({1'b0, rd_entry.prev_angle});
  assign first_frame = match_q.second && !rd_entry.seen;

  always_comb begin
    turns_after = rd_entry.turns;
    if (first_frame) begin
      turns_after = rd_entry.turns;
    end else if (diff > JumpLimit) begin
      turns_after = rd_entry.turns - 32'd1;
    end else if (diff < JumpLimitNeg) begin
      turns_after = rd_entry.turns + 32'd1;
    end
  end

  // Total angle uses the round count from before the update: 8191 = 2^13 - 1.
  assign total = {16'd0, angle_q} + {rd_entry.turns[TurnW-14:0], 13'd0} - rd_entry.turns;

  always_comb begin
    wr_entry.seen       = rd_entry.seen || match_q.second;
    wr_entry.turns      = turns_after;
    wr_entry.prev_angle = angle_q;
  end

  // Control, configuration, held frame and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      first_base_q     <= FirstBaseReset;
      second_base_q    <= SecondBaseReset;
      per_group_q      <= PerGroupReset;
      match_q          <= '0;
      angle_q          <= '0;
      speed_q          <= '0;
      current_q        <= '0;
      temp_q           <= '0;
      out_valid_q      <= 1'b0;
      matched_q        <= 1'b0;
      slot_q           <= '0;
      shaft_angle_q    <= '0;
      shaft_speed_q    <= '0;
      phase_current_q  <= '0;
      temperature_q    <= '0;
      round_count_q    <= '0;
      total_angle_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgFirstBase:  first_base_q  <= cfg_data_i;
          CfgSecondBase: second_base_q <= cfg_data_i;
          CfgPerGroup:   per_group_q   <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_fire) begin
            match_q   <= match;
            angle_q   <= angle_word_i;
            speed_q   <= speed_word_i;
            current_q <= current_word_i;
            temp_q    <= temp_byte_i;
            state_q   <= StCalc;
          end
        end
        StCalc: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
            if (match_q.hit) begin
              matched_q        <= 1'b1;
              slot_q           <= match_q.slot;
              shaft_angle_q    <= angle_q;
              shaft_speed_q    <= speed_q;
              phase_current_q  <= current_q;
              temperature_q    <= temp_q;
              round_count_q    <= turns_after;
              total_angle_q    <= total;
            end else begin
              matched_q        <= 1'b0;
              slot_q           <= '0;
              shaft_angle_q    <= '0;
              shaft_speed_q    <= '0;
              phase_current_q  <= '0;
              temperature_q    <= '0;
              round_count_q    <= '0;
              total_angle_q    <= '0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign matched_o        = matched_q;
  assign slot_o           = slot_q;
  assign shaft_angle_o    = shaft_angle_q;
  assign shaft_speed_o    = shaft_speed_q;
  assign phase_current_o  = phase_current_q;
  assign temperature_o    = temperature_q;
  assign round_count_o    = round_count_q;
  assign total_angle_o    = total_angle_q;

endmodule

`default_nettype wire
